[hw/rtl/tmh_pkg.sv]
// Shared types, codes and constants of the timer min-heap.
package tmh_pkg;

    localparam int ID_W      = 5;
    localparam int ID_COUNT  = 32;
    localparam int OP_W      = 2;
    localparam int ST_W      = 3;
    localparam int OCC_W     = 6;
    localparam int POP_W     = 6;
    localparam int TIME_IN_W = 32;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_ADJUST = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd3;

    localparam logic [ST_W-1:0] ST_DONE    = 3'd0;
    localparam logic [ST_W-1:0] ST_EXPIRED = 3'd1;
    localparam logic [ST_W-1:0] ST_NONE    = 3'd2;
    localparam logic [ST_W-1:0] ST_ABSENT  = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd4;
    localparam logic [ST_W-1:0] ST_PRESENT = 3'd5;

    // heap read address select
    localparam logic [2:0] HA_ROOT   = 3'd0;
    localparam logic [2:0] HA_END    = 3'd1;
    localparam logic [2:0] HA_PARENT = 3'd2;
    localparam logic [2:0] HA_LEFT   = 3'd3;
    localparam logic [2:0] HA_RIGHT  = 3'd4;

    // datapath actions
    localparam logic [3:0] ACT_NONE  = 4'd0;
    localparam logic [3:0] ACT_ADD   = 4'd1;
    localparam logic [3:0] ACT_ADJ   = 4'd2;
    localparam logic [3:0] ACT_DEL   = 4'd3;
    localparam logic [3:0] ACT_MV    = 4'd4;
    localparam logic [3:0] ACT_POP   = 4'd5;
    localparam logic [3:0] ACT_UPMV  = 4'd6;
    localparam logic [3:0] ACT_CHL   = 4'd7;
    localparam logic [3:0] ACT_CHR   = 4'd8;
    localparam logic [3:0] ACT_DNMV  = 4'd9;
    localparam logic [3:0] ACT_PLACE = 4'd10;

    typedef struct packed {
        logic [OP_W-1:0]      operation;
        logic [ID_W-1:0]      timer_id;
        logic [TIME_IN_W-1:0] expire_time;
        logic [TIME_IN_W-1:0] current_time;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0]  fired_id;
        logic [ST_W-1:0]  status;
        logic             last;
        logic [OCC_W-1:0] occupancy;
    } t_out_item;

    typedef struct packed {
        logic            ld_in;
        logic            hrd;
        logic [2:0]      hsel;
        logic            prd;
        logic [3:0]      act;
        logic            emit;
        logic [ST_W-1:0] e_st;
        logic            e_last;
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            present;
        logic            full;
        logic            cnt_zero;
        logic            pos_zero;
        logic            pos_ge_cnt;
        logic            up_less;
        logic            has_left;
        logic            has_right;
        logic            down_more;
        logic            root_due;
        logic            n_max;
        logic            pend;
        logic            out_free;
    } t_dp_sts;

endpackage

[hw/rtl/tmh_datapath.sv]
// Heap and position memories, sift registers and output register.
module tmh_datapath #(
    parameter int CAPACITY  = 32,
    parameter int TIME_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tmh_pkg::t_in_item  i_in_data,
    input  tmh_pkg::t_dp_cmd   i_cmd,
    input  logic               i_out_stall,
    output tmh_pkg::t_dp_sts   o_sts,
    output logic               o_out_valid,
    output tmh_pkg::t_out_item o_out_data
);
    import tmh_pkg::*;

    localparam int CW = $clog2(CAPACITY);
    localparam int NW = $clog2(CAPACITY + 1);
    localparam int XW = CW + 2;

    typedef struct packed {
        logic [ID_W-1:0]      id;
        logic [TIME_BITS-1:0] exp;
    } t_slot;

    t_slot                r_heap [CAPACITY];
    logic [CW-1:0]        r_posm [ID_COUNT];

    logic [OP_W-1:0]      r_op;
    logic [ID_W-1:0]      r_id;
    logic [TIME_BITS-1:0] r_exp;
    logic [TIME_BITS-1:0] r_now;
    logic [NW-1:0]        r_cnt;
    logic [CW-1:0]        r_pos;
    t_slot                r_mv;
    t_slot                r_chd;
    logic [CW-1:0]        r_chd_idx;
    logic [ID_W-1:0]      r_top;
    logic [POP_W-1:0]     r_n;
    logic [ID_COUNT-1:0]  r_present;
    t_slot                r_hrd;
    logic [CW-1:0]        r_prd;
    logic                 r_o_valid;
    t_out_item            r_o_data;

    logic [63:0]          w_e64;
    logic [63:0]          w_n64;
    logic [XW-1:0]        w_lft;
    logic [XW-1:0]        w_rgt;
    logic [CW-1:0]        w_par;
    logic [CW-1:0]        w_haddr;
    logic                 w_hwe;
    t_slot                w_hwd;
    logic                 w_out_free;

    assign w_e64 = {32'd0, i_in_data.expire_time};
    assign w_n64 = {32'd0, i_in_data.current_time};
    assign w_lft = {1'b0, r_pos, 1'b0} + XW'(1);
    assign w_rgt = w_lft + XW'(1);
    assign w_par = (r_pos - CW'(1)) >> 1;
    assign w_out_free = !r_o_valid || !i_out_stall;

    always_comb begin
        case (i_cmd.hsel)
            HA_ROOT:   w_haddr = '0;
            HA_END:    w_haddr = r_cnt[CW-1:0];
            HA_PARENT: w_haddr = w_par;
            HA_LEFT:   w_haddr = w_lft[CW-1:0];
            HA_RIGHT:  w_haddr = w_rgt[CW-1:0];
            default:   w_haddr = '0;
        endcase
    end

    always_comb begin
        w_hwe = 1'b0;
        w_hwd = r_mv;
        case (i_cmd.act)
            ACT_UPMV: begin
                w_hwe = 1'b1;
                w_hwd = r_hrd;
            end
            ACT_DNMV: begin
                w_hwe = 1'b1;
                w_hwd = r_chd;
            end
            ACT_PLACE: w_hwe = 1'b1;
            default:   w_hwe = 1'b0;
        endcase
    end

    // memories: one write and one registered read each per cycle
    always_ff @(posedge i_clk) begin
        if (w_hwe) begin
            r_heap[r_pos]    <= w_hwd;
            r_posm[w_hwd.id] <= r_pos;
        end
        if (i_cmd.hrd) begin
            r_hrd <= r_heap[w_haddr];
        end
        if (i_cmd.prd) begin
            r_prd <= r_posm[r_id];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_op  <= i_in_data.operation;
            r_id  <= i_in_data.timer_id;
            r_exp <= w_e64[TIME_BITS-1:0];
            r_now <= w_n64[TIME_BITS-1:0];
        end
        case (i_cmd.act)
            ACT_ADD: begin
                r_mv  <= '{id: r_id, exp: r_exp};
                r_pos <= r_cnt[CW-1:0];
            end
            ACT_ADJ: begin
                r_mv  <= '{id: r_id, exp: r_exp};
                r_pos <= r_prd;
            end
            ACT_DEL:  r_pos <= r_prd;
            ACT_MV:   r_mv  <= r_hrd;
            ACT_POP: begin
                r_top <= r_hrd.id;
                r_pos <= '0;
            end
            ACT_UPMV: r_pos <= w_par;
            ACT_CHL: begin
                r_chd     <= r_hrd;
                r_chd_idx <= w_lft[CW-1:0];
            end
            ACT_CHR: begin
                if (r_hrd.exp < r_chd.exp) begin
                    r_chd     <= r_hrd;
                    r_chd_idx <= w_rgt[CW-1:0];
                end
            end
            ACT_DNMV: r_pos <= r_chd_idx;
            default: ;
        endcase
        if (i_cmd.emit && w_out_free) begin
            r_o_data.status    <= i_cmd.e_st;
            r_o_data.last      <= i_cmd.e_last;
            r_o_data.occupancy <= OCC_W'(r_cnt);
            if (i_cmd.e_st == ST_NONE) begin
                r_o_data.fired_id <= '0;
            end else if (i_cmd.e_st == ST_EXPIRED) begin
                r_o_data.fired_id <= r_top;
            end else begin
                r_o_data.fired_id <= r_id;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_present <= '0;
            r_n       <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.ld_in) begin
                r_n <= '0;
            end
            case (i_cmd.act)
                ACT_ADD: begin
                    r_cnt           <= r_cnt + NW'(1);
                    r_present[r_id] <= 1'b1;
                end
                ACT_DEL: begin
                    r_cnt           <= r_cnt - NW'(1);
                    r_present[r_id] <= 1'b0;
                end
                ACT_POP: begin
                    r_cnt               <= r_cnt - NW'(1);
                    r_present[r_hrd.id] <= 1'b0;
                    r_n                 <= r_n + POP_W'(1);
                end
                default: ;
            endcase
            if (i_cmd.emit && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.op         = r_op;
        o_sts.present    = r_present[r_id];
        o_sts.full       = r_cnt >= NW'(CAPACITY);
        o_sts.cnt_zero   = r_cnt == '0;
        o_sts.pos_zero   = r_pos == '0;
        o_sts.pos_ge_cnt = NW'(r_pos) >= r_cnt;
        o_sts.up_less    = r_mv.exp < r_hrd.exp;
        o_sts.has_left   = w_lft < XW'(r_cnt);
        o_sts.has_right  = w_rgt < XW'(r_cnt);
        o_sts.down_more  = r_mv.exp > r_chd.exp;
        o_sts.root_due   = r_hrd.exp <= r_now;
        o_sts.n_max      = r_n == POP_W'(ID_COUNT);
        o_sts.pend       = r_n != '0;
        o_sts.out_free   = w_out_free;
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

endmodule

[hw/rtl/tmh_ctrl.sv]
// Operation sequencer of the timer min-heap.
module tmh_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  tmh_pkg::t_dp_sts i_sts,
    output tmh_pkg::t_dp_cmd o_cmd
);
    import tmh_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_POS_W  = 4'd2;
    localparam logic [3:0] S_DL_CHK = 4'd3;
    localparam logic [3:0] S_MV_W   = 4'd4;
    localparam logic [3:0] S_UP_CHK = 4'd5;
    localparam logic [3:0] S_UP_CMP = 4'd6;
    localparam logic [3:0] S_DN_L   = 4'd7;
    localparam logic [3:0] S_DN_LW  = 4'd8;
    localparam logic [3:0] S_DN_RW  = 4'd9;
    localparam logic [3:0] S_DN_CMP = 4'd10;
    localparam logic [3:0] S_TK_RD  = 4'd11;
    localparam logic [3:0] S_TK_CHK = 4'd12;
    localparam logic [3:0] S_TK_POP = 4'd13;
    localparam logic [3:0] S_EMIT   = 4'd14;

    logic [3:0]      r_state;
    logic [3:0]      n_state;
    logic [ST_W-1:0] r_est;
    logic [ST_W-1:0] n_est;
    logic            w_due;
    logic [3:0]      w_place_next;

    assign o_in_stall   = r_state != S_IDLE;
    assign w_due        = !i_sts.cnt_zero && i_sts.root_due && !i_sts.n_max;
    assign w_place_next = (i_sts.op == OP_TICK) ? S_TK_RD : S_EMIT;

    always_comb begin
        n_state = r_state;
        n_est   = r_est;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.ld_in = 1'b1;
                    n_state     = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_sts.op)
                    OP_ADD: begin
                        if (i_sts.present) begin
                            n_est   = ST_PRESENT;
                            n_state = S_EMIT;
                        end else if (i_sts.full) begin
                            n_est   = ST_FULL;
                            n_state = S_EMIT;
                        end else begin
                            o_cmd.act = ACT_ADD;
                            n_state   = S_UP_CHK;
                        end
                    end
                    OP_ADJUST, OP_DELETE: begin
                        if (!i_sts.present) begin
                            n_est   = ST_ABSENT;
                            n_state = S_EMIT;
                        end else begin
                            o_cmd.prd = 1'b1;
                            n_state   = S_POS_W;
                        end
                    end
                    OP_TICK: begin
                        if (i_sts.cnt_zero) begin
                            n_est   = ST_NONE;
                            n_state = S_EMIT;
                        end else begin
                            o_cmd.hrd  = 1'b1;
                            o_cmd.hsel = HA_ROOT;
                            n_state    = S_TK_CHK;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_POS_W: begin
                if (i_sts.op == OP_ADJUST) begin
                    o_cmd.act = ACT_ADJ;
                    n_state   = S_UP_CHK;
                end else begin
                    o_cmd.act = ACT_DEL;
                    n_state   = S_DL_CHK;
                end
            end
            S_DL_CHK: begin
                // deleted entry was the last one: nothing to refill
                if (i_sts.pos_ge_cnt) begin
                    n_est   = ST_DONE;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.hrd  = 1'b1;
                    o_cmd.hsel = HA_END;
                    n_state    = S_MV_W;
                end
            end
            S_MV_W: begin
                o_cmd.act = ACT_MV;
                n_state   = S_UP_CHK;
            end
            S_UP_CHK: begin
                if (i_sts.pos_zero) begin
                    n_state = S_DN_L;
                end else begin
                    o_cmd.hrd  = 1'b1;
                    o_cmd.hsel = HA_PARENT;
                    n_state    = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_sts.up_less) begin
                    o_cmd.act = ACT_UPMV;
                    n_state   = S_UP_CHK;
                end else begin
                    n_state = S_DN_L;
                end
            end
            S_DN_L: begin
                if (i_sts.has_left) begin
                    o_cmd.hrd  = 1'b1;
                    o_cmd.hsel = HA_LEFT;
                    n_state    = S_DN_LW;
                end else begin
                    o_cmd.act = ACT_PLACE;
                    n_est     = ST_DONE;
                    n_state   = w_place_next;
                end
            end
            S_DN_LW: begin
                o_cmd.act = ACT_CHL;
                if (i_sts.has_right) begin
                    o_cmd.hrd  = 1'b1;
                    o_cmd.hsel = HA_RIGHT;
                    n_state    = S_DN_RW;
                end else begin
                    n_state = S_DN_CMP;
                end
            end
            S_DN_RW: begin
                o_cmd.act = ACT_CHR;
                n_state   = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (i_sts.down_more) begin
                    o_cmd.act = ACT_DNMV;
                    n_state   = S_DN_L;
                end else begin
                    o_cmd.act = ACT_PLACE;
                    n_est     = ST_DONE;
                    n_state   = w_place_next;
                end
            end
            S_TK_RD: begin
                if (!i_sts.cnt_zero) begin
                    o_cmd.hrd  = 1'b1;
                    o_cmd.hsel = HA_ROOT;
                end
                n_state = S_TK_CHK;
            end
            S_TK_CHK: begin
                if (i_sts.pend) begin
                    // release the previous pop once we know whether another follows
                    if (i_sts.out_free) begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.e_st   = ST_EXPIRED;
                        o_cmd.e_last = !w_due;
                        if (w_due) begin
                            o_cmd.act = ACT_POP;
                            n_state   = S_TK_POP;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end else if (w_due) begin
                    o_cmd.act = ACT_POP;
                    n_state   = S_TK_POP;
                end else begin
                    n_est   = ST_NONE;
                    n_state = S_EMIT;
                end
            end
            S_TK_POP: begin
                if (i_sts.cnt_zero) begin
                    n_state = S_TK_CHK;
                end else begin
                    o_cmd.hrd  = 1'b1;
                    o_cmd.hsel = HA_END;
                    n_state    = S_MV_W;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.e_st   = r_est;
                    o_cmd.e_last = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_est   <= ST_DONE;
        end else begin
            r_state <= n_state;
            r_est   <= n_est;
        end
    end

endmodule

[hw/rtl/timer_min_heap.sv]
// Top level of the timer min-heap: sequencer plus heap datapath.
// An add or adjust sifts its entry up past later parents, then down past earlier children;
// a delete moves the last entry into the hole and sifts it the same way.
// Tick pops each due timer from the root, refills the root from the end and sifts it down.
// Only one transaction is in flight at a time; a stalled result holds it.
// Reset clears the occupancy, the presence flags and the handshakes; no clearing pass.
module timer_min_heap #(
    parameter int CAPACITY  = 32,
    parameter int TIME_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tmh_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tmh_pkg::t_out_item o_out_data
);
    import tmh_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    tmh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tmh_datapath #(
        .CAPACITY  (CAPACITY),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .i_out_stall (i_out_stall),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
